@@ design/pxrle_pkg.sv @@
// Shared types and constants for the pixel run-length encoder.
// No dependencies; imported by pxrle_front, pxrle_queue and the top level.
`default_nettype none

package pxrle_pkg;

	localparam int CHAN_W = 16;
	localparam int LEN_W  = 9;

	// longest run the length field can carry
	localparam logic [LEN_W-1:0] RUN_CAP = 9'd511;

	// record queue between front and back: depth and pointer width
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;
	localparam int QCW    = 3;

	typedef struct packed {
		logic [LEN_W-1:0]         len;
		logic signed [CHAN_W-1:0] a;
		logic signed [CHAN_W-1:0] b;
		logic signed [CHAN_W-1:0] c;
		logic                     last;
	} rec_t;

	// up to two records written in order per pixel
	typedef struct packed {
		logic v0;
		logic v1;
		rec_t r0;
		rec_t r1;
	} wr_t;

endpackage

`default_nettype wire

@@ design/pixel_run_length_encoder_core.sv @@
// Pixel run-length encoder, top level. Depends on pxrle_pkg, pxrle_front, pxrle_queue.
// A record is visible (empty low) in the cycle after the pixel that closes it.
// Throughput: one pixel per cycle while full is low; the last pixel of a block may write two records,
// set by the two-word write port of the four-entry record queue.
// Reset (arst_n low) empties the queue and clears the run, length and block position.
`default_nettype none

module pixel_run_length_encoder_core import pxrle_pkg::*; #(
	parameter int BLOCK_SIDE = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	output logic                          full,
	input  wire logic signed [CHAN_W-1:0] chan_a,
	input  wire logic signed [CHAN_W-1:0] chan_b,
	input  wire logic signed [CHAN_W-1:0] chan_c,
	output logic                          empty,
	input  wire logic                     pop,
	output logic [LEN_W-1:0]              run_length,
	output logic signed [CHAN_W-1:0]      run_a,
	output logic signed [CHAN_W-1:0]      run_b,
	output logic signed [CHAN_W-1:0]      run_c,
	output logic                          block_end
);

	wr_t  wr;
	rec_t head;

	pxrle_front #(.BLOCK_SIDE(BLOCK_SIDE)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (push && !full),
		.pix_a  (chan_a),
		.pix_b  (chan_b),
		.pix_c  (chan_c),
		.wr     (wr)
	);

	pxrle_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd     (pop),
		.full   (full),
		.empty  (empty),
		.head   (head)
	);

	assign run_length = head.len;
	assign run_a      = head.a;
	assign run_b      = head.b;
	assign run_c      = head.c;
	assign block_end  = head.last;

endmodule

`default_nettype wire

@@ design/pxrle_front.sv @@
// Front end: holds the open run and block position, classifies each pixel
// and produces zero to two records. Depends on pxrle_pkg.
`default_nettype none

module pxrle_front import pxrle_pkg::*; #(
	parameter int BLOCK_SIDE = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     accept,
	input  wire logic signed [CHAN_W-1:0] pix_a,
	input  wire logic signed [CHAN_W-1:0] pix_b,
	input  wire logic signed [CHAN_W-1:0] pix_c,
	output wr_t                           wr
);

	localparam int PIX   = BLOCK_SIDE * BLOCK_SIDE;
	localparam int IDX_W = $clog2(PIX);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PIX - 1);

	logic signed [CHAN_W-1:0] held_a_q, held_b_q, held_c_q;
	logic [LEN_W-1:0]         cnt_q;
	logic [IDX_W-1:0]         idx_q;

	logic             first, match, close, extend, last;
	logic [LEN_W-1:0] cnt_nxt;
	logic signed [CHAN_W-1:0] a_nxt, b_nxt, c_nxt;
	rec_t             rec_closed, rec_final;

	always_comb begin
		first  = (idx_q == '0) || (cnt_q == '0);
		match  = (pix_a == held_a_q) && (pix_b == held_b_q) && (pix_c == held_c_q);
		// a full-length run closes even on a matching pixel
		close  = !first && (!match || (cnt_q >= RUN_CAP));
		extend = !first && match && (cnt_q < RUN_CAP);
		last   = (idx_q == LAST_IDX);

		cnt_nxt = extend ? cnt_q + LEN_W'(1) : LEN_W'(1);
		a_nxt   = extend ? held_a_q : pix_a;
		b_nxt   = extend ? held_b_q : pix_b;
		c_nxt   = extend ? held_c_q : pix_c;

		rec_closed = '{len: cnt_q, a: held_a_q, b: held_b_q, c: held_c_q, last: 1'b0};
		rec_final  = '{len: cnt_nxt, a: a_nxt, b: b_nxt, c: c_nxt, last: 1'b1};

		// compact: closed run goes first, flushed run second
		wr.v0 = accept && (close || last);
		wr.r0 = close ? rec_closed : rec_final;
		wr.v1 = accept && close && last;
		wr.r1 = rec_final;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_a_q <= '0;
			held_b_q <= '0;
			held_c_q <= '0;
			cnt_q    <= '0;
			idx_q    <= '0;
		end else if (accept) begin
			held_a_q <= a_nxt;
			held_b_q <= b_nxt;
			held_c_q <= c_nxt;
			if (last) begin
				cnt_q <= '0;
				idx_q <= '0;
			end else begin
				cnt_q <= cnt_nxt;
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ design/pxrle_queue.sv @@
// Back end: record queue taking up to two words per cycle and handing out
// one per cycle at the result side while rd is high and the queue is not empty. Depends on pxrle_pkg.
`default_nettype none

module pxrle_queue import pxrle_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wr_t       wr,
	input  wire logic rd,
	output logic      full,
	output logic      empty,
	output rec_t      head
);

	rec_t           mem [QDEPTH];
	logic [QAW-1:0] wptr_q, rptr_q;
	logic [QCW-1:0] cnt_q;
	logic [QCW-1:0] n_in;
	logic           pop;

	always_comb begin
		// keep room for the two-word case
		full  = (cnt_q > QCW'(QDEPTH - 2));
		empty = (cnt_q == '0);
		head  = mem[rptr_q];
		pop   = rd && !empty;
		n_in  = QCW'(wr.v0) + QCW'(wr.v1);
	end

	always_ff @(posedge clk) begin
		if (wr.v0)
			mem[wptr_q] <= wr.r0;
		if (wr.v1)
			mem[wptr_q + QAW'(1)] <= wr.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			wptr_q <= wptr_q + QAW'(n_in);
			if (pop)
				rptr_q <= rptr_q + QAW'(1);
			cnt_q <= cnt_q + n_in - QCW'(pop);
		end
	end

endmodule

`default_nettype wire
